[design/psbc_pkg.sv]
// Shared types and constants for the pendulum swing-up and balance controller.
package psbc_pkg;

	localparam int ANGLE_W = 10;
	localparam int SPEED_W = 24;
	localparam int DUTY_W  = 9;
	localparam int GAIN_W  = 16;
	localparam int MS_W    = 16;
	localparam int COUNT_W = 32;
	localparam int LIM_W   = 9;
	localparam int PROD_W  = 41;
	localparam int DIV_STEPS = 24;
	localparam int CNT_W   = 5;

	localparam logic [DUTY_W-1:0]  DUTY_FULL_SCALE = 9'd256;
	localparam logic [9:0]         MS_PER_S        = 10'd1000;
	localparam logic [SPEED_W-1:0] SPEED_MAX       = 24'h7FFFFF;
	localparam logic [SPEED_W-1:0] SPEED_MIN       = 24'h800000;

	localparam logic [GAIN_W-1:0] GAIN_ANGLE_RST = 16'd29850;
	localparam logic [GAIN_W-1:0] GAIN_RATE_RST  = 16'd4117;
	localparam logic [GAIN_W-1:0] SPEED_TOL_RST  = 16'd32;
	localparam logic [LIM_W-1:0]  BAL_THR_RST    = 9'd450;
	localparam logic [LIM_W-1:0]  KICK_WIN_RST   = 9'd16;
	localparam logic [LIM_W-1:0]  BANG_DUTY_RST  = 9'd256;

	typedef enum logic {
		CMD_EDGE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_KICK    = 2'd1,
		MODE_BANG    = 2'd2,
		MODE_BALANCE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_GAIN_ANGLE  = 3'd0,
		REG_GAIN_RATE   = 3'd1,
		REG_SPEED_TOL   = 3'd2,
		REG_BAL_THR     = 3'd3,
		REG_KICK_WIN    = 3'd4,
		REG_BANG_DUTY   = 3'd5,
		REG_SPARE6      = 3'd6,
		REG_SPARE7      = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_DIV,
		S_SAT,
		S_PROD,
		S_FIN
	} back_state_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_angle;
		logic [GAIN_W-1:0] gain_rate;
		logic [GAIN_W-1:0] speed_tolerance;
		logic [LIM_W-1:0]  balance_threshold;
		logic [LIM_W-1:0]  kick_window;
		logic [LIM_W-1:0]  bang_duty;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] delta;
		logic [MS_W-1:0]    ms;
		logic [ANGLE_W-1:0] angle;
	} tick_req_t;

	typedef struct packed {
		logic      valid;
		tick_req_t req;
	} q_head_t;

endpackage

[design/psbc_front.sv]
// Front end: encoder edge counting, angle wrap and tick snapshot into the queue.
module psbc_front #(
	parameter int TICKS_PER_TURN = 1000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          command,
	input  logic                          phase_b_level,
	input  logic [psbc_pkg::MS_W-1:0]     elapsed_ms,
	input  logic                          q_full,
	output logic                          push,
	output psbc_pkg::tick_req_t           push_req
);

	localparam int AW1 = psbc_pkg::ANGLE_W + 1;
	localparam logic [AW1-1:0] TICKS_V = AW1'(TICKS_PER_TURN);
	localparam logic [psbc_pkg::ANGLE_W-1:0] TOP_V = psbc_pkg::ANGLE_W'(TICKS_PER_TURN - 1);

	logic [psbc_pkg::COUNT_W-1:0] position_q;
	logic [psbc_pkg::COUNT_W-1:0] previous_q;
	logic [psbc_pkg::ANGLE_W-1:0] angle_q;
	logic                         accept;
	logic [AW1-1:0]               angle_up;

	assign req_stall = q_full;
	assign accept    = req_valid && !req_stall;
	assign push      = accept && (psbc_pkg::cmd_t'(command) == psbc_pkg::CMD_TICK);
	assign angle_up  = {1'b0, angle_q} + AW1'(1);

	assign push_req.delta = position_q - previous_q;
	assign push_req.ms    = elapsed_ms;
	assign push_req.angle = angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			previous_q <= '0;
			angle_q    <= '0;
		end else if (accept) begin
			if (psbc_pkg::cmd_t'(command) == psbc_pkg::CMD_TICK) begin
				previous_q <= position_q;
			end else if (phase_b_level) begin
				position_q <= position_q - psbc_pkg::COUNT_W'(1);
				angle_q    <= (angle_q == '0 || {1'b0, angle_q} >= TICKS_V) ? TOP_V
				              : angle_q - psbc_pkg::ANGLE_W'(1);
			end else begin
				position_q <= position_q + psbc_pkg::COUNT_W'(1);
				angle_q    <= (angle_up >= TICKS_V) ? '0 : angle_up[psbc_pkg::ANGLE_W-1:0];
			end
		end
	end

endmodule

[design/psbc_queue.sv]
// Two-entry request queue between the front end and the back end.
module psbc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  psbc_pkg::tick_req_t push_req,
	input  logic                pop,
	output logic                full,
	output psbc_pkg::q_head_t   head
);

	logic                v0_q, v1_q;
	psbc_pkg::tick_req_t slot0_q, slot1_q;

	assign full       = v0_q && v1_q;
	assign head.valid = v0_q;
	assign head.req   = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (pop && push) begin
			v0_q <= 1'b1;
		end else if (pop) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end else if (push) begin
			v0_q <= 1'b1;
			v1_q <= v0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && push) begin
			if (v1_q) begin
				slot0_q <= slot1_q;
				slot1_q <= push_req;
			end else begin
				slot0_q <= push_req;
			end
		end else if (pop) begin
			slot0_q <= slot1_q;
		end else if (push) begin
			if (v0_q) begin
				slot1_q <= push_req;
			end else begin
				slot0_q <= push_req;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overrun");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> v0_q)
		else $error("pop from empty queue");

endmodule

[design/psbc_back.sv]
// Back end: speed divider, held state update, mode select and drive law.
module psbc_back #(
	parameter int TICKS_PER_TURN = 1000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psbc_pkg::cfg_t                      cfg,
	input  psbc_pkg::q_head_t                   head,
	output logic                                pop,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [psbc_pkg::DUTY_W-1:0]         duty,
	output logic                                direction,
	output logic [psbc_pkg::ANGLE_W-1:0]        angle_ticks,
	output logic signed [psbc_pkg::SPEED_W-1:0] speed,
	output logic [1:0]                          mode
);

	localparam int AW1 = psbc_pkg::ANGLE_W + 1;
	localparam int AW2 = psbc_pkg::ANGLE_W + 2;
	localparam int PA_W = psbc_pkg::GAIN_W + 1 + AW1;
	localparam int PR_W = psbc_pkg::GAIN_W + 1 + psbc_pkg::SPEED_W;
	localparam int SUM_W = PR_W + 1;
	localparam logic [AW1-1:0] HALF_V  = AW1'(TICKS_PER_TURN / 2);
	localparam logic [AW1-1:0] TICKS_V = AW1'(TICKS_PER_TURN);

	psbc_pkg::back_state_t state_q, state_d;

	logic                                 sign_q;
	logic [psbc_pkg::MS_W-1:0]            ms_q;
	logic [psbc_pkg::ANGLE_W-1:0]         angle_q;
	logic [psbc_pkg::PROD_W-1:0]          prod_q;
	logic [psbc_pkg::MS_W-1:0]            rem_q;
	logic [psbc_pkg::SPEED_W-1:0]         quo_q;
	logic [psbc_pkg::CNT_W-1:0]           cnt_q;
	logic [psbc_pkg::ANGLE_W-1:0]         held_angle_q;
	logic signed [psbc_pkg::SPEED_W-1:0]  held_speed_q;
	logic signed [PA_W-1:0]               pa_q;
	logic signed [PR_W-1:0]               pr_q;
	logic                                 rsp_valid_q;
	logic [psbc_pkg::DUTY_W-1:0]          duty_q;
	logic                                 dir_q;
	logic [psbc_pkg::ANGLE_W-1:0]         angle_out_q;
	logic [psbc_pkg::SPEED_W-1:0]         speed_out_q;
	psbc_pkg::mode_t                      mode_q;

	logic [psbc_pkg::COUNT_W-1:0]         mag;
	logic [psbc_pkg::PROD_W-1:0]          prod_d;
	logic                                 ovf;
	logic [psbc_pkg::MS_W+1:0]            trial;
	logic                                 trial_ok;
	logic [psbc_pkg::SPEED_W-1:0]         sat_speed;
	logic                                 load;

	logic signed [AW1-1:0]                err;
	logic signed [PA_W-1:0]               pa_d;
	logic signed [PR_W-1:0]               pr_d;
	logic signed [SUM_W-1:0]              sum;
	logic [SUM_W-1:0]                     drive_mag;
	logic [SUM_W-9:0]                     drive_duty;
	logic [psbc_pkg::DUTY_W-1:0]          bal_duty;
	logic [psbc_pkg::DUTY_W-1:0]          bang;
	logic [AW1-1:0]                       shifted, wrapped;
	logic signed [AW2-1:0]                vu;
	logic [AW2-1:0]                       bottom_dist;
	logic [psbc_pkg::SPEED_W-1:0]         aspd;
	psbc_pkg::mode_t                      mode_d;
	logic [psbc_pkg::DUTY_W-1:0]          duty_d;
	logic                                 dir_d;

	// Speed numerator: |delta| * 1000.
	assign mag    = head.req.delta[psbc_pkg::COUNT_W-1] ? -head.req.delta : head.req.delta;
	assign prod_d = psbc_pkg::PROD_W'(mag) * psbc_pkg::PROD_W'(psbc_pkg::MS_PER_S);
	assign ovf    = prod_q >= {1'b0, ms_q, {psbc_pkg::SPEED_W{1'b0}}};

	// One restoring step of the division.
	assign trial    = {1'b0, rem_q, quo_q[psbc_pkg::SPEED_W-1]} - {2'b00, ms_q};
	assign trial_ok = !trial[psbc_pkg::MS_W+1];

	always_comb begin
		if (sign_q) begin
			sat_speed = (quo_q > psbc_pkg::SPEED_MIN) ? psbc_pkg::SPEED_MIN : -quo_q;
		end else begin
			sat_speed = quo_q[psbc_pkg::SPEED_W-1] ? psbc_pkg::SPEED_MAX : quo_q;
		end
	end

	// Balance products, registered before the sum.
	assign err  = $signed({1'b0, held_angle_q}) - $signed(HALF_V);
	assign pa_d = $signed({1'b0, cfg.gain_angle}) * err;
	assign pr_d = $signed({1'b0, cfg.gain_rate}) * held_speed_q;

	assign sum        = SUM_W'(pa_q) + SUM_W'(pr_q);
	assign drive_mag  = sum[SUM_W-1] ? -sum : sum;
	assign drive_duty = drive_mag[SUM_W-1:8];
	assign bal_duty   = (drive_duty > (SUM_W-8)'(psbc_pkg::DUTY_FULL_SCALE))
	                    ? psbc_pkg::DUTY_FULL_SCALE : drive_duty[psbc_pkg::DUTY_W-1:0];
	assign bang       = (cfg.bang_duty > psbc_pkg::DUTY_FULL_SCALE)
	                    ? psbc_pkg::DUTY_FULL_SCALE : cfg.bang_duty;

	// Distance from the bottom, true modulo.
	assign shifted     = {1'b0, held_angle_q} + HALF_V;
	assign wrapped     = (shifted >= TICKS_V) ? shifted - TICKS_V : shifted;
	assign vu          = $signed({1'b0, wrapped}) - $signed({1'b0, HALF_V});
	assign bottom_dist = vu[AW2-1] ? AW2'(-vu) : AW2'(vu);
	assign aspd        = held_speed_q[psbc_pkg::SPEED_W-1] ? -held_speed_q : held_speed_q;

	always_comb begin
		mode_d = psbc_pkg::MODE_IDLE;
		duty_d = '0;
		dir_d  = 1'b1;
		if (bottom_dist < AW2'(cfg.balance_threshold)) begin
			if (aspd < psbc_pkg::SPEED_W'(cfg.speed_tolerance)
			    && bottom_dist < AW2'(cfg.kick_window)) begin
				mode_d = psbc_pkg::MODE_KICK;
				duty_d = bang;
			end else if (aspd > psbc_pkg::SPEED_W'(cfg.speed_tolerance)) begin
				mode_d = psbc_pkg::MODE_BANG;
				duty_d = bang;
				dir_d  = !held_speed_q[psbc_pkg::SPEED_W-1];
			end
		end else begin
			mode_d = psbc_pkg::MODE_BALANCE;
			duty_d = bal_duty;
			dir_d  = sum[SUM_W-1] || (sum == '0);
		end
	end

	assign load = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psbc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			psbc_pkg::S_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = psbc_pkg::S_CHK;
				end
			end
			psbc_pkg::S_CHK: begin
				if (ms_q == '0) begin
					state_d = psbc_pkg::S_PROD;
				end else if (ovf) begin
					state_d = psbc_pkg::S_SAT;
				end else begin
					state_d = psbc_pkg::S_DIV;
				end
			end
			psbc_pkg::S_DIV: begin
				if (cnt_q == psbc_pkg::CNT_W'(1)) begin
					state_d = psbc_pkg::S_SAT;
				end
			end
			psbc_pkg::S_SAT:  state_d = psbc_pkg::S_PROD;
			psbc_pkg::S_PROD: state_d = psbc_pkg::S_FIN;
			psbc_pkg::S_FIN: begin
				if (load) begin
					state_d = psbc_pkg::S_IDLE;
				end
			end
			default: state_d = psbc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			psbc_pkg::S_IDLE: begin
				if (head.valid) begin
					sign_q  <= head.req.delta[psbc_pkg::COUNT_W-1];
					ms_q    <= head.req.ms;
					angle_q <= head.req.angle;
					prod_q  <= prod_d;
				end
			end
			psbc_pkg::S_CHK: begin
				rem_q <= prod_q[psbc_pkg::MS_W+psbc_pkg::SPEED_W-1:psbc_pkg::SPEED_W];
				quo_q <= ovf ? '1 : prod_q[psbc_pkg::SPEED_W-1:0];
				cnt_q <= psbc_pkg::CNT_W'(psbc_pkg::DIV_STEPS);
			end
			psbc_pkg::S_DIV: begin
				rem_q <= trial_ok ? trial[psbc_pkg::MS_W-1:0]
				         : {rem_q[psbc_pkg::MS_W-2:0], quo_q[psbc_pkg::SPEED_W-1]};
				quo_q <= {quo_q[psbc_pkg::SPEED_W-2:0], trial_ok};
				cnt_q <= cnt_q - psbc_pkg::CNT_W'(1);
			end
			psbc_pkg::S_PROD: begin
				pa_q <= pa_d;
				pr_q <= pr_d;
			end
			psbc_pkg::S_FIN: begin
				if (load) begin
					duty_q      <= duty_d;
					dir_q       <= dir_d;
					angle_out_q <= held_angle_q;
					speed_out_q <= held_speed_q;
					mode_q      <= mode_d;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_angle_q <= '0;
			held_speed_q <= '0;
		end else if (state_q == psbc_pkg::S_SAT) begin
			held_angle_q <= angle_q;
			held_speed_q <= sat_speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == psbc_pkg::S_FIN && load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign duty        = duty_q;
	assign direction   = dir_q;
	assign angle_ticks = angle_out_q;
	assign speed       = speed_out_q;
	assign mode        = mode_q;

	a_rem_below_ms: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == psbc_pkg::S_DIV |-> rem_q < ms_q)
		else $error("divider remainder out of range");

	a_held_only_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != psbc_pkg::S_SAT |=> $stable(held_speed_q) && $stable(held_angle_q))
		else $error("held state changed outside update");

	a_idle_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && mode_q == psbc_pkg::MODE_IDLE |-> duty_q == '0 && dir_q)
		else $error("idle swing with drive");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == psbc_pkg::S_CHK)
		else $error("pop without start of work");

endmodule

[design/pendulum_swing_up_balance_control.sv]
// Top level of the pendulum swing-up and balance controller with its register port.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_stall  command, phase_b_level, elapsed_ms
//   response  out        rsp_valid/rsp_stall  duty, direction, angle_ticks, speed, mode
//   config    in         APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// Encoder edge requests never produce a response; they wait only on req_stall.
// A control tick runs through the back end as pop, range check, the
// one-bit-per-cycle speed divider, saturate, products and drive.
// A zero elapsed time skips the divider and the held update; a speed
// that overflows 24 bits skips only the divider.
// The front end keeps counting edges while the back end works; a two-entry
// queue holds pending ticks, and req_stall rises only while it is full.
// A finished response waits in its output register; the back end holds in its
// last step only while the previous response is still stalled.
// Reset clears the counts, held angle and speed, and loads the register defaults.
module pendulum_swing_up_balance_control #(
	parameter int TICKS_PER_TURN = 1000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                command,
	input  logic                                phase_b_level,
	input  logic [psbc_pkg::MS_W-1:0]           elapsed_ms,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [psbc_pkg::DUTY_W-1:0]         duty,
	output logic                                direction,
	output logic [psbc_pkg::ANGLE_W-1:0]        angle_ticks,
	output logic signed [psbc_pkg::SPEED_W-1:0] speed,
	output logic [1:0]                          mode,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	psbc_pkg::cfg_t      cfg_q;
	psbc_pkg::reg_idx_t  reg_idx;
	logic                wr_en;

	logic                q_full;
	logic                push;
	logic                pop;
	psbc_pkg::tick_req_t push_req;
	psbc_pkg::q_head_t   head;

	// Register port: word index from paddr[4:2]; write on the access phase.
	assign pready  = 1'b1;
	assign reg_idx = psbc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_angle        <= psbc_pkg::GAIN_ANGLE_RST;
			cfg_q.gain_rate         <= psbc_pkg::GAIN_RATE_RST;
			cfg_q.speed_tolerance   <= psbc_pkg::SPEED_TOL_RST;
			cfg_q.balance_threshold <= psbc_pkg::BAL_THR_RST;
			cfg_q.kick_window       <= psbc_pkg::KICK_WIN_RST;
			cfg_q.bang_duty         <= psbc_pkg::BANG_DUTY_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				psbc_pkg::REG_GAIN_ANGLE: cfg_q.gain_angle <= pwdata[psbc_pkg::GAIN_W-1:0];
				psbc_pkg::REG_GAIN_RATE:  cfg_q.gain_rate  <= pwdata[psbc_pkg::GAIN_W-1:0];
				psbc_pkg::REG_SPEED_TOL:
					cfg_q.speed_tolerance <= pwdata[psbc_pkg::GAIN_W-1:0];
				psbc_pkg::REG_BAL_THR:
					cfg_q.balance_threshold <= pwdata[psbc_pkg::LIM_W-1:0];
				psbc_pkg::REG_KICK_WIN:   cfg_q.kick_window <= pwdata[psbc_pkg::LIM_W-1:0];
				psbc_pkg::REG_BANG_DUTY:  cfg_q.bang_duty   <= pwdata[psbc_pkg::LIM_W-1:0];
				default: ;  // drop writes to unused words
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			psbc_pkg::REG_GAIN_ANGLE: prdata = 32'(cfg_q.gain_angle);
			psbc_pkg::REG_GAIN_RATE:  prdata = 32'(cfg_q.gain_rate);
			psbc_pkg::REG_SPEED_TOL:  prdata = 32'(cfg_q.speed_tolerance);
			psbc_pkg::REG_BAL_THR:    prdata = 32'(cfg_q.balance_threshold);
			psbc_pkg::REG_KICK_WIN:   prdata = 32'(cfg_q.kick_window);
			psbc_pkg::REG_BANG_DUTY:  prdata = 32'(cfg_q.bang_duty);
			default:                  prdata = '0;
		endcase
	end

	// Front end: count edges, snapshot the count delta and angle on each tick.
	psbc_front #(
		.TICKS_PER_TURN(TICKS_PER_TURN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.command      (command),
		.phase_b_level(phase_b_level),
		.elapsed_ms   (elapsed_ms),
		.q_full       (q_full),
		.push         (push),
		.push_req     (push_req)
	);

	// Hold pending ticks so the edge counter waits on the divider only while the queue is full.
	psbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_req(push_req),
		.pop     (pop),
		.full    (q_full),
		.head    (head)
	);

	// Back end: speed, held state, mode and drive.
	psbc_back #(
		.TICKS_PER_TURN(TICKS_PER_TURN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.duty       (duty),
		.direction  (direction),
		.angle_ticks(angle_ticks),
		.speed      (speed),
		.mode       (mode)
	);

endmodule

[bench/pendulum_swing_up_balance_control_tb.sv]
// Self-checking testbench for the pendulum swing-up and balance controller.
`timescale 1ns / 1ps

module pendulum_swing_up_balance_control_tb;
	import psbc_pkg::*;

	localparam int TICKS_PER_TURN = 1000;
	localparam int HALF_TURN      = TICKS_PER_TURN / 2;
	localparam int MS_PER_SECOND  = 1000;
	localparam int SETTLE_CYCLES  = 40;        // about one tick through the back end
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 222;       // at least this many random requests per phase
	localparam int IDLE_PCT       = 68;
	localparam int LIGHT_IDLE_PCT = 7;

	typedef enum logic [1:0] {
		PACE_FREE,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct {
		cmd_t        cmd;
		logic        down;
		logic [15:0] ms;
	} ctl_request_t;

	typedef struct packed {
		logic [DUTY_W-1:0]         duty;
		logic                      direction;
		logic [ANGLE_W-1:0]        angle;
		logic signed [SPEED_W-1:0] speed;
		mode_t                     mode;
	} drive_report_t;

	// DUT ports, all inputs known from time zero
	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       req_valid     = 1'b0;
	logic                       req_stall;
	logic                       command       = 1'b0;
	logic                       phase_b_level = 1'b0;
	logic [MS_W-1:0]            elapsed_ms    = '0;
	logic                       rsp_valid;
	logic                       rsp_stall     = 1'b0;
	logic [DUTY_W-1:0]          duty;
	logic                       direction;
	logic [ANGLE_W-1:0]         angle_ticks;
	logic signed [SPEED_W-1:0]  speed;
	logic [1:0]                 mode;
	logic                       psel          = 1'b0;
	logic                       penable       = 1'b0;
	logic                       pwrite        = 1'b0;
	logic [4:0]                 paddr         = '0;
	logic [31:0]                pwdata        = '0;
	logic [31:0]                prdata;
	logic                       pready;

	// stimulus and scoreboard
	ctl_request_t  pending_requests[$];
	drive_report_t expected_reports[$];
	int            fail_count         = 0;
	int            cycle_count        = 0;
	int            sender_gap_pct     = 0;
	int            receiver_stall_pct = 0;
	logic          drift_down         = 1'b0;

	// controller shadow: encoder, latched tick values and register copy
	logic [COUNT_W-1:0]        enc_count;
	logic [ANGLE_W-1:0]        enc_angle;
	logic [COUNT_W-1:0]        last_tick_count;
	logic [ANGLE_W-1:0]        latched_angle;
	logic signed [SPEED_W-1:0] latched_speed;
	cfg_t                      ctl_cfg;

	pendulum_swing_up_balance_control #(
		.TICKS_PER_TURN(TICKS_PER_TURN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.phase_b_level(phase_b_level),
		.elapsed_ms(elapsed_ms),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.duty(duty),
		.direction(direction),
		.angle_ticks(angle_ticks),
		.speed(speed),
		.mode(mode),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance the shadow controller by one accepted request. An edge moves the
	// count and the wrapped angle; a tick latches angle and speed, picks the mode
	// and queues the drive it must report.
	function automatic void advance_controller(input cmd_t cmd, input logic down,
			input logic [MS_W-1:0] ms);
		longint        delta, ms_l, rate, a, vu, bottom_dist, spd, aspd, tol, err, drive, mag;
		longint        ga, gr;
		logic [COUNT_W-1:0] diff;
		logic [DUTY_W-1:0]  bang;
		drive_report_t rep;
		if (cmd == CMD_EDGE) begin
			if (down) begin
				enc_count = enc_count - 1'b1;
				enc_angle = (enc_angle == 0) ? ANGLE_W'(TICKS_PER_TURN - 1) : enc_angle - 1'b1;
			end else begin
				enc_count = enc_count + 1'b1;
				enc_angle = (enc_angle + 1 >= TICKS_PER_TURN) ? '0 : enc_angle + 1'b1;
			end
			return;
		end

		// speed over the interval; zero elapsed time keeps the latched values
		diff = enc_count - last_tick_count;
		delta = $signed(diff);
		ms_l = ms;
		if (ms != 0) begin
			rate = (delta * MS_PER_SECOND) / ms_l;
			if (rate > 8388607)
				rate = 8388607;
			if (rate < -8388608)
				rate = -8388608;
			latched_angle = enc_angle;
			latched_speed = SPEED_W'(rate);
		end
		last_tick_count = enc_count;

		a = latched_angle;
		vu = (a + HALF_TURN) % TICKS_PER_TURN - HALF_TURN;
		bottom_dist = (vu < 0) ? -vu : vu;
		spd = latched_speed;
		aspd = (spd < 0) ? -spd : spd;
		tol = ctl_cfg.speed_tolerance;
		bang = (ctl_cfg.bang_duty > DUTY_FULL_SCALE) ? DUTY_FULL_SCALE : ctl_cfg.bang_duty;

		rep.duty = '0;
		rep.direction = 1'b1;
		rep.mode = MODE_IDLE;
		rep.angle = latched_angle;
		rep.speed = latched_speed;
		if (bottom_dist < longint'(ctl_cfg.balance_threshold)) begin
			if (aspd < tol && bottom_dist < longint'(ctl_cfg.kick_window)) begin
				rep.mode = MODE_KICK;
				rep.duty = bang;
			end else if (aspd > tol) begin
				rep.mode = MODE_BANG;
				rep.duty = bang;
				rep.direction = (spd >= 0);
			end
		end else begin
			ga = ctl_cfg.gain_angle;
			gr = ctl_cfg.gain_rate;
			err = a - HALF_TURN;
			drive = -(ga * err + gr * spd);
			mag = (drive < 0) ? -drive : drive;
			rep.mode = MODE_BALANCE;
			rep.direction = (drive >= 0);
			rep.duty = ((mag >> 8) > DUTY_FULL_SCALE) ? DUTY_FULL_SCALE : DUTY_W'(mag >> 8);
		end
		expected_reports.push_back(rep);
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			fail_count++;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// Request driver: hold the payload while stalled, otherwise present the next
	// pending request or idle at the phase's rate.
	always @(posedge clk) begin : drive_requests
		ctl_request_t nxt;
		if (arst_n) begin
			if (req_valid && !req_stall)
				advance_controller(cmd_t'(command), phase_b_level, elapsed_ms);
			if (!req_valid || !req_stall) begin
				if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
					nxt = pending_requests.pop_front();
					req_valid <= 1'b1;
					command <= nxt.cmd;
					phase_b_level <= nxt.down;
					elapsed_ms <= nxt.ms;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare each accepted drive report with the oldest
	// prediction, then pick the stall for the next cycle.
	always @(posedge clk) begin : check_reports
		drive_report_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_reports.size() == 0) begin
					fail_count++;
					$error("unexpected response: duty %0d direction %0d angle %0d speed %0d mode %0d",
						duty, direction, angle_ticks, speed, mode);
				end else begin
					want = expected_reports.pop_front();
					check_field("duty", want.duty, duty);
					check_field("direction", want.direction, direction);
					check_field("angle_ticks", want.angle, angle_ticks);
					check_field("speed", want.speed, speed);
					check_field("mode", want.mode, mode);
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("pendulum_swing_up_balance_control regression: fail");
			$finish;
		end
	end

	function automatic void queue_request(input cmd_t cmd, input logic down, input logic [15:0] ms);
		ctl_request_t r;
		r.cmd = cmd;
		r.down = down;
		r.ms = ms;
		pending_requests.push_back(r);
	endfunction

	// Mostly short intervals so speeds stay in a useful range; drop in zero,
	// the full-scale value and wide random ones now and then.
	function automatic logic [15:0] pick_elapsed();
		case ($urandom_range(0, 15))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 65535));
			3:       return 16'($urandom_range(256, 4096));
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	// One swing: a run of edges that mostly follow the current drift, then a
	// tick. Occasional noisy runs scatter directions. Returns requests queued.
	function automatic int queue_swing_sequence();
		int   run_len;
		logic noisy;
		logic dir_bit;
		run_len = $urandom_range(0, 24);
		noisy = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 7) == 0)
			drift_down = !drift_down;
		for (int i = 0; i < run_len; i++) begin
			if (noisy)
				dir_bit = 1'($urandom_range(0, 1));
			else
				dir_bit = ($urandom_range(0, 15) == 0) ? !drift_down : drift_down;
			queue_request(CMD_EDGE, dir_bit, 16'($urandom_range(0, 65535)));
		end
		queue_request(CMD_TICK, 1'($urandom_range(0, 1)), pick_elapsed());
		return run_len + 1;
	endfunction

	task automatic set_pace(input pace_t pace);
		sender_gap_pct = (pace == PACE_SENDER_IDLE) ? IDLE_PCT :
			(pace == PACE_BOTH) ? LIGHT_IDLE_PCT : 0;
		receiver_stall_pct = (pace == PACE_RECEIVER_STALL) ? IDLE_PCT :
			(pace == PACE_BOTH) ? LIGHT_IDLE_PCT : 0;
	endtask

	// Register write: setup then access; the write lands at the access edge.
	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAIN_ANGLE: ctl_cfg.gain_angle = value[GAIN_W-1:0];
			REG_GAIN_RATE:  ctl_cfg.gain_rate = value[GAIN_W-1:0];
			REG_SPEED_TOL:  ctl_cfg.speed_tolerance = value[GAIN_W-1:0];
			REG_BAL_THR:    ctl_cfg.balance_threshold = value[LIM_W-1:0];
			REG_KICK_WIN:   ctl_cfg.kick_window = value[LIM_W-1:0];
			REG_BANG_DUTY:  ctl_cfg.bang_duty = value[LIM_W-1:0];
			default: ;
		endcase
	endtask

	// Load all six registers; random upper bits and a spare-slot write must be
	// ignored by the block.
	task automatic apply_settings(input logic [15:0] ga, input logic [15:0] gr,
			input logic [15:0] tol, input logic [8:0] thr, input logic [8:0] kw,
			input logic [8:0] bd);
		write_register(REG_GAIN_ANGLE, {16'($urandom), ga});
		write_register(REG_GAIN_RATE, {16'($urandom), gr});
		write_register(REG_SPEED_TOL, {16'($urandom), tol});
		write_register(REG_BAL_THR, {23'($urandom), thr});
		write_register(REG_KICK_WIN, {23'($urandom), kw});
		write_register(REG_BANG_DUTY, {23'($urandom), bd});
		write_register(REG_SPARE6, $urandom);
	endtask

	// Wait until every request is taken and every report checked, then give the
	// back end time to go quiet before touching registers.
	task automatic drain_and_settle();
		@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : run_phases
		int   queued;
		logic [8:0] thr;

		// shadow state matches the block after reset
		enc_count = '0;
		enc_angle = '0;
		last_tick_count = '0;
		latched_angle = '0;
		latched_speed = '0;
		ctl_cfg.gain_angle = GAIN_ANGLE_RST;
		ctl_cfg.gain_rate = GAIN_RATE_RST;
		ctl_cfg.speed_tolerance = SPEED_TOL_RST;
		ctl_cfg.balance_threshold = BAL_THR_RST;
		ctl_cfg.kick_window = KICK_WIN_RST;
		ctl_cfg.bang_duty = BANG_DUTY_RST;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under reset settings.
		@(negedge clk);
		set_pace(PACE_FREE);
		queue_request(CMD_TICK, 1'b0, 16'd0);          // zero elapsed right after reset: kick
		queue_request(CMD_TICK, 1'b1, 16'hFFFF);       // phase B ignored on a tick
		queue_request(CMD_EDGE, 1'b1, 16'hFFFF);       // wrap below zero, ms ignored
		queue_request(CMD_TICK, 1'b0, 16'd1);          // negative speed: bang reverse
		queue_request(CMD_EDGE, 1'b0, 16'd0);          // wrap back to zero
		queue_request(CMD_TICK, 1'b0, 16'd31);         // speed equals tolerance: idle
		queue_request(CMD_TICK, 1'b1, 16'd0);          // zero elapsed keeps latched values
		queue_request(CMD_EDGE, 1'b0, 16'hA5A5);
		queue_request(CMD_EDGE, 1'b0, 16'h5A5A);
		queue_request(CMD_TICK, 1'b0, 16'hFFFF);       // speed truncates to zero: kick
		queue_request(CMD_TICK, 1'b0, 16'd1);
		queue_request(CMD_EDGE, 1'b0, 16'h0001);
		queue_request(CMD_TICK, 1'b0, 16'd1);          // bang forward
		queue_request(CMD_TICK, 1'b1, 16'h8000);
		queue_request(CMD_EDGE, 1'b1, 16'h8000);
		queue_request(CMD_EDGE, 1'b1, 16'h7FFF);
		queue_request(CMD_TICK, 1'b0, 16'd3);          // negative quotient truncates toward zero
		drain_and_settle();

		// Random phases, each under its own register setting and pacing.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_settings(GAIN_ANGLE_RST, GAIN_RATE_RST, SPEED_TOL_RST,
					BAL_THR_RST, KICK_WIN_RST, BANG_DUTY_RST);
				1: apply_settings('0, '0, '0, '0, '0, '0);
				2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF, 9'h1FF, 9'h1FF);
				3: begin
					// narrow swing region so balance gets plenty of ticks
					thr = 9'($urandom_range(0, 120));
					apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 2000)),
						16'($urandom_range(0, 3000)), thr, 9'($urandom_range(0, thr)),
						9'($urandom_range(0, 511)));
				end
				default: begin
					thr = 9'($urandom_range(0, 511));
					apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), thr, 9'($urandom_range(0, 511)),
						9'($urandom_range(0, 511)));
				end
			endcase
			@(negedge clk);
			set_pace(pace_t'(p % 4));
			queued = 0;
			while (queued < PHASE_REQUESTS)
				queued += queue_swing_sequence();
			drain_and_settle();
		end

		if (fail_count == 0 && expected_reports.size() == 0)
			$display("pendulum_swing_up_balance_control regression: pass");
		else
			$display("pendulum_swing_up_balance_control regression: fail");
		$finish;
	end

endmodule
